/* src/fcgm_pkg.sv */
// Shared types and constants of the code point to glyph map.
// No dependencies; every other file but fcgm_ram takes names from here.
package fcgm_pkg;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int CP_W    = 16;
   localparam int GLYPH_W = 16;
   localparam int CSR_W   = 16;

   // Item kinds on the request channel
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // Configuration register indexes
   localparam logic CSR_MAP_ENABLE  = 1'b0;
   localparam logic CSR_GLYPH_COUNT = 1'b1;

   // Register reset values
   localparam logic [CSR_W-1:0] GLYPH_COUNT_RESET = 16'd256;

   // Table byte that moves on to the next glyph
   localparam logic [BYTE_W-1:0] GLYPH_ADVANCE = 8'hFF;

   // UTF-8 lead byte payload masks and continuation byte payload width
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
   localparam int                CONT_BITS  = 6;

   // Controller to datapath commands
   typedef struct packed {
      logic clear;        // write zero at the sweep address
      logic load;         // apply one table byte
      logic lookup_start; // capture code point, start the map read
      logic result_load;  // latch the clamped glyph into the output register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;   // sweep is at the last map entry
   } status_type;

endpackage

/* src/fcgm_req_if.sv */
// Request channel of the glyph map: valid/ready plus one item.
// Depends on fcgm_pkg for field widths.
interface fcgm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [fcgm_pkg::BYTE_W-1:0] table_byte;
   logic [fcgm_pkg::CP_W-1:0]   code_point;

   modport source (output valid, req_type, table_byte, code_point, input ready);
   modport sink   (input valid, req_type, table_byte, code_point, output ready);
endinterface

/* src/fcgm_rsp_if.sv */
// Result channel of the glyph map: valid/ready plus the glyph index.
// Depends on fcgm_pkg for field widths.
interface fcgm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fcgm_pkg::GLYPH_W-1:0] glyph_index;

   modport source (output valid, glyph_index, input ready);
   modport sink   (input valid, glyph_index, output ready);
endinterface

/* src/fcgm_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module fcgm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/fcgm_dp.sv */
// Datapath of the glyph map: UTF-8 table decoder, map RAM, clear sweep,
// configuration registers and the output register. Uses fcgm_pkg, fcgm_ram.
module fcgm_dp #(
   parameter int MAP_DEPTH = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fcgm_pkg::cmd_type            cmd,
   output fcgm_pkg::status_type         status,
   input  logic [fcgm_pkg::BYTE_W-1:0]  table_byte,
   input  logic [fcgm_pkg::CP_W-1:0]    code_point,
   input  logic                         csr_wr_en,
   input  logic                         csr_index,
   input  logic [fcgm_pkg::CSR_W-1:0]   csr_wdata,
   output logic [fcgm_pkg::GLYPH_W-1:0] glyph_index
);
   localparam int AW = $clog2(MAP_DEPTH);
   localparam logic [fcgm_pkg::CP_W:0] DEPTH_LIM = (fcgm_pkg::CP_W + 1)'(MAP_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_DEPTH - 1);

   // Configuration registers
   logic                         map_enable_ff;
   logic [fcgm_pkg::CSR_W-1:0]   glyph_count_ff;

   // Decoder state
   logic [fcgm_pkg::GLYPH_W-1:0] glyph_ctr_ff, glyph_ctr_in;
   logic [1:0]                   pending_ff, pending_in;
   logic [fcgm_pkg::CP_W-1:0]    partial_ff, partial_in;

   // Sweep, lookup and output registers
   logic [AW-1:0]                clr_addr_ff;
   logic [fcgm_pkg::CP_W-1:0]    cp_ff;
   logic                         cp_hit_ff;
   logic [fcgm_pkg::GLYPH_W-1:0] glyph_ff, glyph_in;

   // Map port signals
   logic                         dec_wr;
   logic [fcgm_pkg::CP_W-1:0]    dec_cp;
   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [fcgm_pkg::GLYPH_W-1:0] ram_wdata;
   logic [AW-1:0]                ram_raddr;
   logic [fcgm_pkg::GLYPH_W-1:0] ram_rdata;
   logic [fcgm_pkg::GLYPH_W-1:0] mapped;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         map_enable_ff  <= 1'b0;
         glyph_count_ff <= fcgm_pkg::GLYPH_COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fcgm_pkg::CSR_MAP_ENABLE:  map_enable_ff  <= csr_wdata[0];
            fcgm_pkg::CSR_GLYPH_COUNT: glyph_count_ff <= csr_wdata;
            default:                   map_enable_ff  <= map_enable_ff;
         endcase
      end
   end

   // UTF-8 decode of one table byte; a pending sequence swallows any byte
   always_comb begin
      glyph_ctr_in = glyph_ctr_ff;
      pending_in   = pending_ff;
      partial_in   = partial_ff;
      dec_wr       = 1'b0;
      dec_cp       = '0;
      priority if (pending_ff != 2'd0) begin
         partial_in = {partial_ff[fcgm_pkg::CP_W-fcgm_pkg::CONT_BITS-1:0],
                       table_byte[fcgm_pkg::CONT_BITS-1:0]};
         pending_in = pending_ff - 2'd1;
         if (pending_ff == 2'd1) begin
            dec_wr = 1'b1;
            dec_cp = partial_in;
         end
      end else if (table_byte == fcgm_pkg::GLYPH_ADVANCE) begin
         glyph_ctr_in = glyph_ctr_ff + 16'd1;
      end else if (!table_byte[7]) begin
         dec_wr = 1'b1;
         dec_cp = {8'd0, table_byte};
      end else if (!table_byte[5]) begin
         partial_in = {8'd0, table_byte & fcgm_pkg::LEAD2_MASK};
         pending_in = 2'd1;
      end else if (!table_byte[4]) begin
         partial_in = {8'd0, table_byte & fcgm_pkg::LEAD3_MASK};
         pending_in = 2'd2;
      end else if (!table_byte[3]) begin
         partial_in = {8'd0, table_byte & fcgm_pkg::LEAD4_MASK};
         pending_in = 2'd3;
      end else begin
         // invalid lead byte maps code point zero
         dec_wr = 1'b1;
         dec_cp = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_ctr_ff <= '0;
         pending_ff   <= '0;
         partial_ff   <= '0;
         clr_addr_ff  <= '0;
      end else begin
         if (cmd.load) begin
            glyph_ctr_ff <= glyph_ctr_in;
            pending_ff   <= pending_in;
            partial_ff   <= partial_in;
         end
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
      end
   end

   assign status.clear_last = (clr_addr_ff == LAST_ADDR);

   // Map write port: the sweep owns it during clearing
   always_comb begin
      if (cmd.clear) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = cmd.load && dec_wr && ({1'b0, dec_cp} < DEPTH_LIM);
         ram_waddr = dec_cp[AW-1:0];
         ram_wdata = glyph_ctr_ff;
      end
   end

   // Read address straight from the request on the accept cycle, then held
   assign ram_raddr = cmd.lookup_start ? code_point[AW-1:0] : cp_ff[AW-1:0];

   fcgm_ram #(
      .WIDTH (fcgm_pkg::GLYPH_W),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Lookup: translate, then clamp to zero outside 1 .. glyph_count-1
   always_comb begin
      if (map_enable_ff) begin
         mapped = cp_hit_ff ? ram_rdata : '0;
      end else begin
         mapped = cp_ff;
      end
      glyph_in = ((mapped != '0) && (mapped < glyph_count_ff)) ? mapped : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup_start) begin
         cp_ff     <= code_point;
         cp_hit_ff <= ({1'b0, code_point} < DEPTH_LIM);
      end
      if (cmd.result_load) begin
         glyph_ff <= glyph_in;
      end
   end

   assign glyph_index = glyph_ff;
endmodule

/* src/fcgm_ctrl.sv */
// Controller of the glyph map: clear sweep after reset, item acceptance,
// lookup sequencing and result valid. Uses fcgm_pkg.
module fcgm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_type,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fcgm_pkg::cmd_type    cmd,
   input  fcgm_pkg::status_type status
);
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == fcgm_pkg::REQ_LOOKUP) begin
                  cmd.lookup_start = 1'b1;
                  state_in         = ST_READ;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_READ: begin
            // map data is ready; wait for room in the output register
            if (slot_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase

      priority if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

/* src/font_codepoint_glyph_map.sv */
// Code point to glyph map for a bitmap console font with a unicode table.
// Request channel req_ch carries items of two kinds: a load item brings one
// byte of the font's unicode table (0xFF moves on to the next glyph, other
// bytes are UTF-8 decoded and map the code point to the current glyph) and
// gives no result; a lookup item translates a code point and gives one
// glyph_index item on rsp_ch. csr_* writes map_enable (index 0) and
// glyph_count (index 1); the user must do so only while the block is idle,
// as the block does not enforce it. A load item is taken in ST_IDLE; a
// lookup goes on to ST_READ, with req_ch.ready low, for the registered read
// of the map RAM. Loads keep streaming while a result waits.
// Reset: a clearing sweep writes zero to every map entry, one per cycle;
// req_ch.ready stays low until it ends. Configuration writes are taken
// during the sweep.
// Stall: a result waits in the output register until rsp_ch.ready; a lookup
// behind it holds its read until the register is free, then the block takes
// new items again.
// Depends on fcgm_pkg, fcgm_req_if, fcgm_rsp_if, fcgm_ram, fcgm_dp, fcgm_ctrl.
module font_codepoint_glyph_map #(
   parameter int MAP_DEPTH = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   fcgm_req_if.sink                   req_ch,
   fcgm_rsp_if.source                 rsp_ch,
   input  logic                       csr_wr_en,
   input  logic                       csr_index,
   input  logic [fcgm_pkg::CSR_W-1:0] csr_wdata
);
   fcgm_pkg::cmd_type    cmd;
   fcgm_pkg::status_type status;

   fcgm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   fcgm_dp #(
      .MAP_DEPTH (MAP_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .table_byte  (req_ch.table_byte),
      .code_point  (req_ch.code_point),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .glyph_index (rsp_ch.glyph_index)
   );

   // No items taken while the sweep runs
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_ch.ready)
      else $error("request accepted during map clear");

   // A new result never overwrites one still waiting
   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result register overwritten");

   // An accepted lookup blocks the request side for its read cycle
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.req_type == fcgm_pkg::REQ_LOOKUP)
      |=> !req_ch.ready)
      else $error("request taken during map read");

   // Only one command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("conflicting datapath commands");
endmodule

/* tb/fcgm_glyph_checker.sv */
`timescale 1ns / 1ps
// Checker for the code point to glyph map: keeps its own copy of the map,
// predicts each lookup's glyph and compares the results in order.
// Depends on fcgm_pkg, fcgm_req_if and fcgm_rsp_if.
module fcgm_glyph_checker #(
   parameter int MAP_DEPTH = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   fcgm_req_if                        req_ch,
   fcgm_rsp_if                        rsp_ch,
   input  logic                       csr_wr_en,
   input  logic                       csr_index,
   input  logic [fcgm_pkg::CSR_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         results_waiting,
   output int                         loads_seen,
   output int                         lookups_seen
);
   import fcgm_pkg::*;

   // Predicted registers and decode state
   logic                map_on;
   logic [GLYPH_W-1:0]  glyph_limit;
   logic [GLYPH_W-1:0]  glyph_now;
   logic [1:0]          cont_left;
   logic [CP_W-1:0]     cp_partial;
   logic [GLYPH_W-1:0]  glyph_of [MAP_DEPTH];

   // Glyphs owed by accepted lookups, oldest first
   logic [GLYPH_W-1:0]  expected_glyphs [$];
   logic [GLYPH_W-1:0]  want;
   int                  n_fail = 0;
   int                  n_load = 0;
   int                  n_lookup = 0;

   // Entries beyond the map are dropped
   function automatic void map_store(input logic [CP_W-1:0] cp);
      if (int'(cp) < MAP_DEPTH) glyph_of[cp] = glyph_now;
   endfunction

   // One table byte: continuation first, then advance, then lead-byte pattern
   function automatic void take_table_byte(input logic [BYTE_W-1:0] b);
      if (cont_left != 2'd0) begin
         // unchecked continuation, even 0xFF; shifted value kept to 16 bits
         cp_partial = {cp_partial[CP_W-7:0], b[5:0]};
         cont_left  = cont_left - 2'd1;
         if (cont_left == 2'd0) map_store(cp_partial);
      end else if (b == GLYPH_ADVANCE) begin
         glyph_now = glyph_now + 1'b1;
      end else if (!b[7]) begin
         map_store(CP_W'(b));
      end else if (!b[5]) begin
         cp_partial = CP_W'(b[4:0]);
         cont_left  = 2'd1;
      end else if (!b[4]) begin
         cp_partial = CP_W'(b[3:0]);
         cont_left  = 2'd2;
      end else if (!b[3]) begin
         cp_partial = CP_W'(b[2:0]);
         cont_left  = 2'd3;
      end else begin
         // invalid lead byte maps code point zero
         map_store('0);
      end
   endfunction

   // Translate, then clamp anything outside 1 .. glyph_count-1 to zero
   function automatic logic [GLYPH_W-1:0] glyph_for(input logic [CP_W-1:0] cp);
      logic [GLYPH_W-1:0] g;
      g = cp;
      if (map_on) g = (int'(cp) < MAP_DEPTH) ? glyph_of[cp] : '0;
      if (!(g > 0 && g < glyph_limit)) g = '0;
      return g;
   endfunction

   // Track writes, accepted items and results at each edge
   always @(posedge clock) begin
      if (reset) begin
         map_on      = 1'b0;
         glyph_limit = GLYPH_COUNT_RESET;
         glyph_now   = '0;
         cont_left   = 2'd0;
         cp_partial  = '0;
         for (int i = 0; i < MAP_DEPTH; i++) glyph_of[i] = '0;
         expected_glyphs.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_MAP_ENABLE) map_on = csr_wdata[0];
            else if (csr_index == CSR_GLYPH_COUNT) glyph_limit = csr_wdata[GLYPH_W-1:0];
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.req_type == REQ_LOAD) begin
               take_table_byte(req_ch.table_byte);
               n_load++;
            end else begin
               expected_glyphs.push_back(glyph_for(req_ch.code_point));
               n_lookup++;
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_glyphs.size() == 0) begin
               $error("glyph_index: expected no item, got %0h", rsp_ch.glyph_index);
               n_fail++;
            end else begin
               want = expected_glyphs.pop_front();
               if (rsp_ch.glyph_index !== want) begin
                  $error("glyph_index mismatch: expected %0h, got %0h",
                         want, rsp_ch.glyph_index);
                  n_fail++;
               end
            end
         end
      end
      fail_count      <= n_fail;
      results_waiting <= expected_glyphs.size();
      loads_seen      <= n_load;
      lookups_seen    <= n_lookup;
   end

endmodule

/* tb/tb_font_codepoint_glyph_map.sv */
`timescale 1ns / 1ps
// Top of the glyph map testbench: clock, reset, stimulus and verdict.
// Depends on fcgm_pkg, both channel interfaces, the block and fcgm_glyph_checker.
module tb_font_codepoint_glyph_map;
   import fcgm_pkg::*;

   localparam int MAP_DEPTH       = 65536;
   localparam int HOLD_CYCLES     = 200;
   localparam int SETTLE_CYCLES   = 4;
   localparam int SETTLE_LIMIT    = 100000;
   localparam int ITEMS_PER_PHASE = 290;
   localparam int TIMEOUT_NS      = 20_000_000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en;
   logic             csr_index;
   logic [CSR_W-1:0] csr_wdata;

   fcgm_req_if req_ch();
   fcgm_rsp_if rsp_ch();

   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int hold_request = 0;
   int items_sent   = 0;
   int fail_count, results_waiting, loads_seen, lookups_seen;

   // Code points recently loaded, so that lookups hit the map
   logic [CP_W-1:0] loaded_cps [$];

   always #5 clock = ~clock;

   font_codepoint_glyph_map #(.MAP_DEPTH(MAP_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fcgm_glyph_checker #(.MAP_DEPTH(MAP_DEPTH)) glyph_check (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .results_waiting (results_waiting),
      .loads_seen      (loads_seen),
      .lookups_seen    (lookups_seen)
   );

   // Result side: random stalls, plus a long hold-off when asked
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
         end
      end
   end

   // Offer one item after any random gap, return once it is taken
   task automatic push_item(input logic kind, input logic [BYTE_W-1:0] b,
                            input logic [CP_W-1:0] cp);
      while (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.table_byte <= b;
      req_ch.code_point <= cp;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic send_load(input logic [BYTE_W-1:0] b);
      push_item(REQ_LOAD, b, CP_W'($urandom));
   endtask

   task automatic send_lookup(input logic [CP_W-1:0] cp);
      push_item(REQ_LOOKUP, BYTE_W'($urandom), cp);
   endtask

   // Stop offering and wait for every owed glyph before going on
   task automatic settle();
      int waited;
      waited = 0;
      req_ch.valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (results_waiting != 0 && waited < SETTLE_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers, one per cycle; the caller is to run it only while idle, which the task does not enforce
   task automatic write_config(input logic en, input logic [CSR_W-1:0] count);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAP_ENABLE;
      csr_wdata <= CSR_W'(en);
      @(posedge clock);
      csr_index <= CSR_GLYPH_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly loaded code points, some random, some low
   function automatic logic [CP_W-1:0] pick_lookup_cp();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60 && loaded_cps.size() > 0)
         return loaded_cps[$urandom_range(0, loaded_cps.size() - 1)];
      else if (r < 80)
         return CP_W'($urandom);
      else
         return CP_W'($urandom_range(0, 255));
   endfunction

   // Well-formed UTF-8 for one code point; four-byte form carries a plane
   task automatic send_utf8(input logic [CP_W-1:0] cp, input bit four_byte);
      logic [20:0] wide_cp;
      wide_cp = {5'($urandom_range(1, 16)), cp};
      if (four_byte) begin
         send_load({5'b11110, wide_cp[20:18]});
         send_load({2'b10, wide_cp[17:12]});
         send_load({2'b10, wide_cp[11:6]});
         send_load({2'b10, wide_cp[5:0]});
      end else if (cp < 16'h0080) begin
         send_load(cp[7:0]);
      end else if (cp < 16'h0800) begin
         send_load({3'b110, cp[10:6]});
         send_load({2'b10, cp[5:0]});
      end else begin
         send_load({4'b1110, cp[15:12]});
         send_load({2'b10, cp[11:6]});
         send_load({2'b10, cp[5:0]});
      end
      loaded_cps.push_back(cp);
      if (loaded_cps.size() > 64) void'(loaded_cps.pop_front());
   endtask

   // One random sequence: advance, load, noise, broken load or lookup
   task automatic random_sequence();
      int r;
      logic [CP_W-1:0] cp;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         send_load(GLYPH_ADVANCE);
      end else if (r < 40) begin
         case ($urandom_range(0, 2))
            0:       cp = CP_W'($urandom_range(0, 127));
            1:       cp = CP_W'($urandom_range(128, 2047));
            default: cp = CP_W'($urandom);
         endcase
         send_utf8(cp, $urandom_range(0, 9) == 0);
      end else if (r < 48) begin
         send_load(BYTE_W'($urandom));
      end else if (r < 54) begin
         // byte 0xC0..0xFF, mostly a lead byte, a lookup in the middle of its decode, then any byte
         send_load({2'b11, 6'($urandom)});
         send_lookup(pick_lookup_cp());
         send_load(BYTE_W'($urandom));
      end else begin
         send_lookup(pick_lookup_cp());
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct,
                            input logic en, input logic [CSR_W-1:0] count);
      int phase_end;
      settle();
      write_config(en, count);
      send_gap_pct = send_pct;
      recv_gap_pct = recv_pct;
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) random_sequence();
   endtask

   // Stimulus and verdict
   initial begin
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_LOAD;
      req_ch.table_byte <= '0;
      req_ch.code_point <= '0;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_MAP_ENABLE;
      csr_wdata         <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: every lead-byte form, glyph advance, decode edge cases
      write_config(1'b1, 16'hFFFF);
      send_load(8'h41);
      send_load(GLYPH_ADVANCE);
      send_load(8'h42);
      send_load(8'hC3);
      send_load(8'hA9);
      send_load(8'hE2);
      send_lookup(16'h0042);            // lookup inside a three-byte decode
      send_load(8'h82);
      send_load(8'hAC);
      send_load(GLYPH_ADVANCE);
      send_load(8'hF0);                 // four-byte form, truncated to 16 bits
      send_load(8'h9F);
      send_load(8'h98);
      send_load(8'h80);
      send_load(8'hF8);                 // invalid leads map code point zero
      send_load(8'hFE);
      send_load(8'hC2);
      send_load(GLYPH_ADVANCE);         // taken as a continuation, not an advance
      send_lookup(16'h0000);
      send_lookup(16'h0041);
      send_lookup(16'h00E9);
      send_lookup(16'h20AC);
      send_lookup(16'hF600);
      send_lookup(16'h00BF);
      send_lookup(16'hFFFF);
      settle();
      write_config(1'b1, 16'h0000);
      send_lookup(16'h0042);
      settle();
      write_config(1'b0, 16'hFFFF);
      send_lookup(16'hFFFF);
      send_lookup(16'h1234);

      // Result side held off while lookups keep coming, then drain fully
      settle();
      write_config(1'b1, 16'hFFFF);
      hold_request = HOLD_CYCLES;
      repeat (40) send_lookup(pick_lookup_cp());

      // Random phases with different idling and register settings
      run_phase(11, 61, 1'b1, 16'hFFFF);
      run_phase(61, 11, 1'b0, 16'd1000);
      run_phase(0, 0, 1'b1, 16'd60);
      settle();

      if (results_waiting != 0)
         $error("%0d glyph items never arrived", results_waiting);
      $display("Covered %0d table bytes and %0d lookups: directed decode cases,",
               loads_seen, lookups_seen);
      $display("a long result stall with a full block and three random phases.");
      if (fail_count == 0 && results_waiting == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
